// File: rtl/i2cm2_pkg.sv
// Package for the two-byte I2C write master.
// Holds the phase type, register indexes, reset values and the structs shared
// by the sequencer and the top level. Depends on nothing.
package i2cm2_pkg;

    // Sequencer phases.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_BITS  = 3'd2,
        PH_ACK   = 3'd3,
        PH_STOP  = 3'd4
    } t_phase;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_BYTE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_BYTE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TICKS  = 3'd4;

    // Register values after reset.
    localparam logic [6:0]  RST_SLAVE_ADDR  = 7'h4D;
    localparam logic [7:0]  RST_FIRST_BYTE  = 8'd24;
    localparam logic [7:0]  RST_SECOND_BYTE = 8'd11;
    localparam logic [15:0] RST_HALF_PERIOD = 16'd50;
    localparam logic [23:0] RST_IDLE_TICKS  = 24'd2000;

    // Number of data bytes after the address byte.
    localparam logic [1:0] LAST_BYTE_IDX = 2'd2;

    // Current configuration as seen by the sequencer.
    typedef struct packed {
        logic [6:0]  slave_addr;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [15:0] half_period;
        logic [23:0] idle_ticks;
    } t_cfg;

    // Line levels and pulses produced for one tick.
    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic sda_release;
        logic nack_seen;
        logic transfer_done;
    } t_result;

endpackage

// File: rtl/i2cm2_seq.sv
// Tick sequencer of the two-byte I2C write master.
// Holds the phase, tick, bit and byte state and computes the line levels of
// each tick. Depends on i2cm2_pkg.
module i2cm2_seq #(
    parameter int unsigned COUNTER_WIDTH = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_sda_in,
    input  i2cm2_pkg::t_cfg   i_cfg,
    output i2cm2_pkg::t_result o_res
);
    import i2cm2_pkg::*;

    localparam int unsigned CW = COUNTER_WIDTH;
    localparam int unsigned CMPW = ((CW > 24) ? CW : 24) + 1;

    t_phase         r_phase, n_phase;
    logic [CW-1:0]  r_tick, n_tick;
    logic [2:0]     r_bit, n_bit;
    logic [1:0]     r_byte, n_byte;
    logic [7:0]     r_shift, n_shift;
    logic           r_clk_hi, n_clk_hi;

    logic [15:0]    half_len;
    logic [CMPW-1:0] tick_plus;
    logic [CMPW-1:0] idle_ext;
    logic [CMPW-1:0] cnt_max;
    logic [CMPW-1:0] idle_lim;
    logic           half_end;
    logic           idle_end;
    logic [CW-1:0]  tick_inc;
    logic [1:0]     byte_inc;

    // Half-bit and idle end detection.
    always_comb begin
        half_len  = (i_cfg.half_period == 16'd0) ? 16'd1 : i_cfg.half_period;
        tick_plus = CMPW'(r_tick) + CMPW'(1);
        idle_ext  = CMPW'(i_cfg.idle_ticks);
        cnt_max   = {{(CMPW-CW){1'b0}}, {CW{1'b1}}};
        idle_lim  = (idle_ext > cnt_max) ? cnt_max : idle_ext;
        half_end  = tick_plus >= CMPW'(half_len);
        idle_end  = tick_plus >= idle_lim;
        tick_inc  = r_tick + CW'(1);
        byte_inc  = r_byte + 2'd1;
    end

    // Next state and line levels.
    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_byte   = r_byte;
        n_shift  = r_shift;
        n_clk_hi = r_clk_hi;
        o_res    = '{scl_level: 1'b1, sda_level: 1'b1, sda_release: 1'b0,
                     nack_seen: 1'b0, transfer_done: 1'b0};
        unique case (r_phase)
            PH_START: begin
                o_res.sda_level = 1'b0;
                if (half_end) begin
                    n_shift  = {i_cfg.slave_addr, 1'b0};
                    n_bit    = 3'd0;
                    n_byte   = 2'd0;
                    n_phase  = PH_BITS;
                    n_tick   = '0;
                    n_clk_hi = 1'b0;
                end else begin
                    n_tick = tick_inc;
                end
            end
            PH_BITS: begin
                o_res.scl_level = r_clk_hi;
                o_res.sda_level = r_shift[7];
                if (!half_end) begin
                    n_tick = tick_inc;
                end else if (!r_clk_hi) begin
                    n_clk_hi = 1'b1;
                    n_tick   = '0;
                end else begin
                    n_shift  = {r_shift[6:0], 1'b0};
                    n_tick   = '0;
                    n_clk_hi = 1'b0;
                    if (r_bit == 3'd7) begin
                        n_bit   = 3'd0;
                        n_phase = PH_ACK;
                    end else begin
                        n_bit = r_bit + 3'd1;
                    end
                end
            end
            PH_ACK: begin
                o_res.scl_level   = r_clk_hi;
                o_res.sda_release = 1'b1;
                if (!half_end) begin
                    n_tick = tick_inc;
                end else if (!r_clk_hi) begin
                    n_clk_hi = 1'b1;
                    n_tick   = '0;
                end else if (i_sda_in) begin
                    // No acknowledge: back to idle and retry.
                    o_res.nack_seen = 1'b1;
                    n_phase  = PH_IDLE;
                    n_tick   = '0;
                    n_clk_hi = 1'b1;
                end else if (r_byte >= LAST_BYTE_IDX) begin
                    n_phase  = PH_STOP;
                    n_tick   = '0;
                    n_clk_hi = 1'b0;
                end else begin
                    n_byte   = byte_inc;
                    n_shift  = (byte_inc == 2'd1) ? i_cfg.first_byte : i_cfg.second_byte;
                    n_bit    = 3'd0;
                    n_phase  = PH_BITS;
                    n_tick   = '0;
                    n_clk_hi = 1'b0;
                end
            end
            PH_STOP: begin
                o_res.scl_level = r_clk_hi;
                o_res.sda_level = 1'b0;
                if (!half_end) begin
                    n_tick = tick_inc;
                end else if (!r_clk_hi) begin
                    n_clk_hi = 1'b1;
                    n_tick   = '0;
                end else begin
                    o_res.transfer_done = 1'b1;
                    n_phase  = PH_IDLE;
                    n_tick   = '0;
                    n_clk_hi = 1'b1;
                end
            end
            default: begin
                // Idle wait with both lines high.
                if (idle_end) begin
                    n_phase  = PH_START;
                    n_tick   = '0;
                    n_clk_hi = 1'b1;
                end else begin
                    n_tick = tick_inc;
                end
            end
        endcase
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_tick   <= '0;
            r_bit    <= 3'd0;
            r_byte   <= 2'd0;
            r_shift  <= 8'd0;
            r_clk_hi <= 1'b1;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_bit    <= n_bit;
            r_byte   <= n_byte;
            r_shift  <= n_shift;
            r_clk_hi <= n_clk_hi;
        end
    end

endmodule

// File: rtl/i2c_master_two_byte_write.sv
// Top level of the two-byte I2C write master.
// Holds the configuration registers and the result register around the
// tick sequencer. Depends on i2cm2_pkg and i2cm2_seq.
//
// Usage: each input beat is one timebase tick carrying the sampled SDA level
// (i_sda_in). Every accepted input beat produces exactly one output beat with
// the SCL and SDA levels to drive, the SDA release flag and the one-tick
// NACK and done pulses. The sequencer loops forever: idle wait, start,
// address and write bit, ACK, two data bytes each with an ACK, stop.
// A NACK returns it to the idle wait and the transfer is retried.
// Each output beat is registered in the single result register behind the
// sequencer; throughput is one beat per cycle while the receiver is ready.
// Input ready stays high while the result register is empty or being
// drained, so a stalled receiver holds the input side as well, and nothing
// is lost. Reset (synchronous, active low) restores the register defaults,
// returns the sequencer to the idle wait and empties the result register.
// Configuration writes take effect at once; the address and data bytes are
// loaded when their byte starts. Writes to unknown indexes are dropped.
module i2c_master_two_byte_write #(
    parameter int unsigned COUNTER_WIDTH = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [i2cm2_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [i2cm2_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_sda_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_scl_level,
    output logic                                o_sda_level,
    output logic                                o_sda_release,
    output logic                                o_nack_seen,
    output logic                                o_transfer_done
);
    import i2cm2_pkg::*;

    t_cfg    r_cfg;
    t_result seq_res;
    t_result r_res;
    logic    r_out_valid;
    logic    in_accept;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_addr  <= RST_SLAVE_ADDR;
            r_cfg.first_byte  <= RST_FIRST_BYTE;
            r_cfg.second_byte <= RST_SECOND_BYTE;
            r_cfg.half_period <= RST_HALF_PERIOD;
            r_cfg.idle_ticks  <= RST_IDLE_TICKS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_SLAVE_ADDR:  r_cfg.slave_addr  <= i_cfg_data[6:0];
                REG_FIRST_BYTE:  r_cfg.first_byte  <= i_cfg_data[7:0];
                REG_SECOND_BYTE: r_cfg.second_byte <= i_cfg_data[7:0];
                REG_HALF_PERIOD: r_cfg.half_period <= i_cfg_data[15:0];
                REG_IDLE_TICKS:  r_cfg.idle_ticks  <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Input beat is taken whenever the result register can take its result.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    i2cm2_seq #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_accept),
        .i_sda_in (i_sda_in),
        .i_cfg    (r_cfg),
        .o_res    (seq_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= seq_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_scl_level     = r_res.scl_level;
    assign o_sda_level     = r_res.sda_level;
    assign o_sda_release   = r_res.sda_release;
    assign o_nack_seen     = r_res.nack_seen;
    assign o_transfer_done = r_res.transfer_done;

endmodule

// File: verif/testbench.sv
// Testbench for the two-byte I2C write master.
// Drives sampled SDA ticks, mirrors the bus sequencer and checks every output beat.
// Depends on i2cm2_pkg and i2c_master_two_byte_write.
`timescale 1ns / 100ps

module testbench;
    import i2cm2_pkg::*;

    localparam int unsigned CNT_W = 24;
    localparam longint CNT_MAX = (longint'(1) << CNT_W) - 1;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned TICK_TARGET = 1550;
    localparam int unsigned DRAIN_CYCLES = 3;
    localparam int NO_FORCED_NACK = -1;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_sda_in = 1'b1;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b1;
    logic                  o_scl_level;
    logic                  o_sda_level;
    logic                  o_sda_release;
    logic                  o_nack_seen;
    logic                  o_transfer_done;

    // Mirror of the configuration registers and the bus sequencer.
    t_cfg             cfg_mirror = '{slave_addr: RST_SLAVE_ADDR, first_byte: RST_FIRST_BYTE,
                                     second_byte: RST_SECOND_BYTE,
                                     half_period: RST_HALF_PERIOD,
                                     idle_ticks: RST_IDLE_TICKS};
    t_phase           seq_phase = PH_IDLE;
    logic [CNT_W-1:0] seq_ticks = '0;
    logic [3:0]       seq_bit = '0;
    logic [1:0]       seq_byte = '0;
    logic [7:0]       seq_shift = '0;
    logic             seq_scl_high = 1'b1;

    // Expected line levels, oldest first.
    t_result bus_levels_due[$];

    int unsigned error_count = 0;
    int unsigned ticks_sent = 0;
    int unsigned reg_writes = 0;
    int unsigned writes_completed = 0;
    int unsigned nacks_predicted = 0;
    int unsigned cycle_count = 0;

    // Stimulus knobs shared by the test tasks.
    int          nack_pct = 0;
    int          nack_byte = NO_FORCED_NACK;
    bit          gaps_on = 1'b1;
    int          burst_left = 0;
    int unsigned hold_request = 0;

    i2c_master_two_byte_write #(
        .COUNTER_WIDTH(CNT_W)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sda_in       (i_sda_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_scl_level    (o_scl_level),
        .o_sda_level    (o_sda_level),
        .o_sda_release  (o_sda_release),
        .o_nack_seen    (o_nack_seen),
        .o_transfer_done(o_transfer_done)
    );

    // Free-running 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still due", cycle_count,
                     bus_levels_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // True when the current half bit ends on this tick.
    function automatic bit half_over();
        longint half_len;
        half_len = (cfg_mirror.half_period == '0) ? 1 : longint'(cfg_mirror.half_period);
        return longint'(seq_ticks) + 1 >= half_len;
    endfunction

    task automatic enter_phase(input t_phase next_phase);
        seq_phase = next_phase;
        seq_ticks = '0;
        seq_scl_high = (next_phase == PH_IDLE || next_phase == PH_START);
    endtask

    // Advances the sequencer mirror by one tick and returns the line levels.
    task automatic advance_bus(input logic sda_sample, output t_result levels);
        longint idle_len;
        levels.scl_level = 1'b1;
        levels.sda_level = 1'b1;
        levels.sda_release = 1'b0;
        levels.nack_seen = 1'b0;
        levels.transfer_done = 1'b0;
        case (seq_phase)
            PH_START: begin
                levels.sda_level = 1'b0;
                if (half_over()) begin
                    seq_shift = {cfg_mirror.slave_addr, 1'b0};
                    seq_bit = '0;
                    seq_byte = '0;
                    enter_phase(PH_BITS);
                end else begin
                    seq_ticks = seq_ticks + 1'b1;
                end
            end
            PH_BITS: begin
                levels.scl_level = seq_scl_high;
                levels.sda_level = seq_shift[7];
                if (!half_over()) begin
                    seq_ticks = seq_ticks + 1'b1;
                end else if (!seq_scl_high) begin
                    seq_scl_high = 1'b1;
                    seq_ticks = '0;
                end else begin
                    seq_shift = seq_shift << 1;
                    if (seq_bit >= 4'd7) begin
                        seq_bit = '0;
                        enter_phase(PH_ACK);
                    end else begin
                        seq_bit = seq_bit + 1'b1;
                        seq_scl_high = 1'b0;
                        seq_ticks = '0;
                    end
                end
            end
            PH_ACK: begin
                levels.scl_level = seq_scl_high;
                levels.sda_release = 1'b1;
                if (!half_over()) begin
                    seq_ticks = seq_ticks + 1'b1;
                end else if (!seq_scl_high) begin
                    seq_scl_high = 1'b1;
                    seq_ticks = '0;
                end else if (sda_sample) begin
                    levels.nack_seen = 1'b1;
                    enter_phase(PH_IDLE);
                end else if (seq_byte >= LAST_BYTE_IDX) begin
                    enter_phase(PH_STOP);
                end else begin
                    seq_byte = seq_byte + 1'b1;
                    seq_shift = (seq_byte == 2'd1) ? cfg_mirror.first_byte
                                                   : cfg_mirror.second_byte;
                    seq_bit = '0;
                    enter_phase(PH_BITS);
                end
            end
            PH_STOP: begin
                levels.scl_level = seq_scl_high;
                levels.sda_level = 1'b0;
                if (!half_over()) begin
                    seq_ticks = seq_ticks + 1'b1;
                end else if (!seq_scl_high) begin
                    seq_scl_high = 1'b1;
                    seq_ticks = '0;
                end else begin
                    levels.transfer_done = 1'b1;
                    enter_phase(PH_IDLE);
                end
            end
            default: begin
                // Idle wait; an idle count beyond the counter range is clipped.
                idle_len = (longint'(cfg_mirror.idle_ticks) > CNT_MAX)
                           ? CNT_MAX : longint'(cfg_mirror.idle_ticks);
                if (longint'(seq_ticks) + 1 >= idle_len) begin
                    enter_phase(PH_START);
                end else begin
                    seq_ticks = seq_ticks + 1'b1;
                end
            end
        endcase
    endtask

    // Picks the next SDA sample: mostly ACKs in ACK slots, noise elsewhere.
    function automatic logic pick_sda();
        if (seq_phase == PH_ACK) begin
            if (nack_byte == int'(seq_byte)) begin
                return 1'b1;
            end
            return ($urandom_range(0, 99) < nack_pct);
        end
        return 1'($urandom_range(0, 1));
    endfunction

    // Sends one tick beat and records the levels it must produce.
    task automatic send_tick(input logic sda_sample);
        t_result levels;
        i_in_valid <= 1'b1;
        i_sda_in <= sda_sample;
        do @(posedge i_clk); while (!o_in_ready);
        advance_bus(sda_sample, levels);
        bus_levels_due.push_back(levels);
        ticks_sent++;
        if (levels.transfer_done) begin
            writes_completed++;
        end
        if (levels.nack_seen) begin
            nacks_predicted++;
        end
    endtask

    // Sender bursts: random burst length, then maybe a random gap.
    task automatic pace();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            if (gaps_on && $urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_ticks(input int unsigned count);
        repeat (count) begin
            send_tick(pick_sda());
            pace();
        end
        end_burst();
    endtask

    // Holds the sender until every due beat has come out.
    task automatic wait_idle();
        while (bus_levels_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register and mirrors it; only called with nothing in flight.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (index)
            REG_SLAVE_ADDR:  cfg_mirror.slave_addr = data[6:0];
            REG_FIRST_BYTE:  cfg_mirror.first_byte = data[7:0];
            REG_SECOND_BYTE: cfg_mirror.second_byte = data[7:0];
            REG_HALF_PERIOD: cfg_mirror.half_period = data[15:0];
            REG_IDLE_TICKS:  cfg_mirror.idle_ticks = data[23:0];
            default: ;
        endcase
        reg_writes++;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic want, input logic got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compares each output beat with the oldest due levels.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (bus_levels_due.size() == 0) begin
                $display("%0t ns: unexpected output beat, expected none, actual scl=%0b sda=%0b",
                         $time, o_scl_level, o_sda_level);
                error_count++;
            end else begin
                want = bus_levels_due.pop_front();
                check_field("scl_level", want.scl_level, o_scl_level);
                check_field("sda_level", want.sda_level, o_sda_level);
                check_field("sda_release", want.sda_release, o_sda_release);
                check_field("nack_seen", want.nack_seen, o_nack_seen);
                check_field("transfer_done", want.transfer_done, o_transfer_done);
            end
        end
    end

    // Receiver: open, random or patterned stalls, plus a long hold on request.
    t_rx_mode    rx_mode = RX_OPEN;
    int unsigned rx_mode_left = 0;
    int unsigned rx_hold_left = 0;
    logic [11:0] rx_pattern = 12'b1101_1001_0111;

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            rx_hold_left = hold_request;
            hold_request = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 2));
                rx_mode_left = $urandom_range(32, 400);
            end else begin
                rx_mode_left--;
            end
            rx_pattern = {rx_pattern[10:0], rx_pattern[11]};
            case (rx_mode)
                RX_OPEN:   i_out_ready <= 1'b1;
                RX_RANDOM: i_out_ready <= ($urandom_range(0, 3) != 0);
                default:   i_out_ready <= rx_pattern[0];
            endcase
        end
    end

    // Reset values hold the bus idle with both lines high.
    task automatic test_reset_values();
        run_ticks(12);
        wait_idle();
    endtask

    // Zero half period and zero idle both act as one tick; a full write completes.
    task automatic test_minimum_timing();
        nack_pct = 0;
        cfg_write(REG_HALF_PERIOD, {8'($urandom), 16'd0});
        cfg_write(REG_IDLE_TICKS, 24'd0);
        run_ticks(70);
        wait_idle();
    endtask

    // A NACK in each of the three ACK slots sends the master back to idle.
    task automatic test_nack_each_slot();
        cfg_write(REG_HALF_PERIOD, 24'd1);
        for (int slot = 0; slot <= int'(LAST_BYTE_IDX); slot++) begin
            nack_byte = slot;
            run_ticks(62);
            wait_idle();
        end
        nack_byte = NO_FORCED_NACK;
    endtask

    // Address and data extremes, with random spare high bits in the write data.
    task automatic test_register_extremes();
        logic [6:0] addrs[3] = '{7'h00, 7'h7F, 7'h2A};
        logic [7:0] firsts[3] = '{8'h00, 8'hFF, 8'hA5};
        logic [7:0] seconds[3] = '{8'hFF, 8'h00, 8'h5A};
        for (int k = 0; k < 3; k++) begin
            cfg_write(REG_SLAVE_ADDR, {17'($urandom), addrs[k]});
            cfg_write(REG_FIRST_BYTE, {16'($urandom), firsts[k]});
            cfg_write(REG_SECOND_BYTE, {16'($urandom), seconds[k]});
            run_ticks(62);
            wait_idle();
        end
    endtask

    // Writes to indexes past the last register must change nothing.
    task automatic test_unused_indexes();
        for (int idx = int'(REG_IDLE_TICKS) + 1; idx < (1 << CFG_IDX_W); idx++) begin
            cfg_write(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
        end
        run_ticks(62);
        wait_idle();
    endtask

    // Largest idle count and half period, entered from the idle wait.
    task automatic test_slow_timing();
        nack_pct = 0;
        while (seq_phase != PH_IDLE) begin
            send_tick(pick_sda());
        end
        end_burst();
        wait_idle();
        cfg_write(REG_IDLE_TICKS, 24'hFF_FFFF);
        run_ticks(20);
        wait_idle();
        cfg_write(REG_HALF_PERIOD, 24'h00_FFFF);
        cfg_write(REG_IDLE_TICKS, 24'd0);
        run_ticks(30);
        wait_idle();
    endtask

    // Receiver holds off while the sender keeps offering beats.
    task automatic test_backpressure();
        cfg_write(REG_HALF_PERIOD, 24'd1);
        cfg_write(REG_IDLE_TICKS, 24'd2);
        gaps_on = 1'b0;
        hold_request = 300;
        run_ticks(120);
        wait_idle();
        gaps_on = 1'b1;
    endtask

    // Random settings and bus traffic, mostly well-formed writes with some NACKs.
    task automatic test_random_traffic();
        int unsigned half_len;
        int unsigned idle_len;
        while (ticks_sent < TICK_TARGET) begin
            half_len = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12)
                                                   : $urandom_range(0, 3);
            idle_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40)
                                                   : $urandom_range(0, 6);
            if ($urandom_range(0, 1)) begin
                cfg_write(REG_SLAVE_ADDR, CFG_DATA_W'($urandom));
            end
            if ($urandom_range(0, 1)) begin
                cfg_write(REG_FIRST_BYTE, CFG_DATA_W'($urandom));
            end
            if ($urandom_range(0, 1)) begin
                cfg_write(REG_SECOND_BYTE, CFG_DATA_W'($urandom));
            end
            if ($urandom_range(0, 7) == 0) begin
                cfg_write(REG_IDLE_TICKS + 1'b1, CFG_DATA_W'($urandom));
            end
            cfg_write(REG_HALF_PERIOD, {8'($urandom), 16'(half_len)});
            cfg_write(REG_IDLE_TICKS, 24'(idle_len));
            case ($urandom_range(0, 2))
                0:       nack_pct = 0;
                1:       nack_pct = 5;
                default: nack_pct = 25;
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            run_ticks($urandom_range(80, 250));
            wait_idle();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_minimum_timing();
        test_nack_each_slot();
        test_register_extremes();
        test_unused_indexes();
        test_slow_timing();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d bus ticks and %0d register writes,", ticks_sent, reg_writes);
        $display("with %0d completed two-byte writes and %0d NACK retries.",
                 writes_completed, nacks_predicted);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
